// ----- hw/rtl/code_region_interval_table_macros.svh -----
// Assertion helpers for the region table. Both expect clk and rst_n in scope.
`ifndef CODE_REGION_INTERVAL_TABLE_MACROS_SVH
`define CODE_REGION_INTERVAL_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRIT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/crit_pkg.sv -----
`default_nettype none

package crit_pkg;

    localparam int ADDR_W   = 64;
    localparam int HANDLE_W = 6;
    localparam int GEN_W    = 32;
    localparam int COUNT_W  = 7;

    localparam logic [2:0] OP_STAGE      = 3'd0;
    localparam logic [2:0] OP_REGISTER   = 3'd1;
    localparam logic [2:0] OP_REMOVE_HND = 3'd2;
    localparam logic [2:0] OP_REMOVE_OVL = 3'd3;
    localparam logic [2:0] OP_LOOKUP     = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic pop;
        logic push;
    } crit_shift_t;

endpackage

`default_nettype wire

// ----- hw/rtl/crit_cell.sv -----
`default_nettype none

module crit_cell
    import crit_pkg::*;
#(
    parameter int EW  = 8,
    parameter int LW  = 2,
    parameter int IDX = 0
)
(
    input  wire logic          clk,
    input  wire crit_shift_t   ctl,
    input  wire logic [LW-1:0] wr,
    input  wire logic [EW-1:0] next_entry,
    input  wire logic [EW-1:0] push_entry,
    output logic      [EW-1:0] entry
);

    logic [EW-1:0] entry_reg;
    logic [EW-1:0] entry_next;
    logic          take;

    always_comb
    begin
        take       = ctl.push && (wr == LW'(IDX));
        entry_next = entry_reg;
        if (take)
        begin
            entry_next = push_entry;
        end
        else if (ctl.pop)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/code_region_interval_table.sv -----
// Channel  | Handshake                     | Payload
// request  | request_valid, request_ready  | operation, handle, range_begin, range_end,
//          |                               | lookup_address
// result   | result_valid, result_ready    | status, found_handle, found_generation,
//          |                               | removed_count
//
// Stage requests and rejected requests go from the check state straight to the output;
// register, remove and lookup requests first make a pass over the table. The row of cells
// hands the table past its head one entry per cycle, but remove overlapping stops for a
// generation update after every entry that it drops. After reset the generation memory is
// cleared, one handle a cycle, before the first request is taken. A stalled result lets the
// block take one more request, which then waits for the output register to free up.
`default_nettype none

`include "code_region_interval_table_macros.svh"

module code_region_interval_table
    import crit_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int SUBRANGES     = 4,
    parameter int HANDLES       = 64
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                request_valid,
    output logic                     request_ready,
    input  wire logic [2:0]          operation,
    input  wire logic [HANDLE_W-1:0] handle,
    input  wire logic [ADDR_W-1:0]   range_begin,
    input  wire logic [ADDR_W-1:0]   range_end,
    input  wire logic [ADDR_W-1:0]   lookup_address,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output logic [1:0]               status,
    output logic [HANDLE_W-1:0]      found_handle,
    output logic [GEN_W-1:0]         found_generation,
    output logic [COUNT_W-1:0]       removed_count
);

    localparam int LW   = $clog2(TABLE_ENTRIES + 1);
    localparam int SCW  = $clog2(SUBRANGES + 1);
    localparam int HW   = $clog2(HANDLES);
    localparam int SUBO = SUBRANGES * 2 * ADDR_W;
    localparam int OWNO = SUBO + SCW;
    localparam int ENDO = OWNO + HANDLE_W;
    localparam int BEGO = ENDO + ADDR_W;
    localparam int EW   = BEGO + ADDR_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_PASS  = 3'd3;
    localparam logic [2:0] S_GUPD  = 3'd4;
    localparam logic [2:0] S_GRD   = 3'd5;
    localparam logic [2:0] S_GWR   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [HANDLE_W-1:0] h_reg, h_next;
    logic [ADDR_W-1:0]   b_reg, b_next;
    logic [ADDR_W-1:0]   e_reg, e_next;
    logic [ADDR_W-1:0]   a_reg, a_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [LW-1:0]       pass_cnt_reg, pass_cnt_next;
    logic                ins_pend_reg, ins_pend_next;
    logic [EW-1:0]       ins_reg, ins_next;
    logic [1:0]          st_reg, st_next;
    logic                found_reg, found_next;
    logic                hit_reg, hit_next;
    logic [HANDLE_W-1:0] fh_reg, fh_next;
    logic [GEN_W-1:0]    fg_reg, fg_next;
    logic [LW-1:0]       rm_cnt_reg, rm_cnt_next;
    logic [HW-1:0]       gaddr_reg, gaddr_next;
    logic [SCW-1:0]      staged_cnt_reg, staged_cnt_next;
    logic [ADDR_W-1:0]   stg_b_reg [SUBRANGES];
    logic [ADDR_W-1:0]   stg_b_next [SUBRANGES];
    logic [ADDR_W-1:0]   stg_e_reg [SUBRANGES];
    logic [ADDR_W-1:0]   stg_e_next [SUBRANGES];
    logic [HW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_st_reg, out_st_next;
    logic [HANDLE_W-1:0] out_fh_reg, out_fh_next;
    logic [GEN_W-1:0]    out_fg_reg, out_fg_next;
    logic [COUNT_W-1:0]  out_rm_reg, out_rm_next;

    logic [GEN_W-1:0]    gen_mem [HANDLES];
    logic [GEN_W-1:0]    gen_rd_reg;
    logic [HW-1:0]       gen_raddr;
    logic                gen_we;
    logic [HW-1:0]       gen_waddr;
    logic [GEN_W-1:0]    gen_wdata;

    crit_shift_t         ctl;
    logic [LW-1:0]       wr;
    logic [EW-1:0]       push_entry;
    logic [EW-1:0]       cell_q [TABLE_ENTRIES];
    logic [EW-1:0]       head;
    logic [ADDR_W-1:0]   hd_b, hd_e;
    logic [HANDLE_W-1:0] hd_own;
    logic [SCW-1:0]      hd_sc;
    logic                hd_ovl;
    logic                bad;
    logic [EW-1:0]       new_entry;
    logic [31:0]         rm_wide;

    assign request_ready = (state_reg == S_IDLE);
    assign result_valid  = out_valid_reg;
    assign status           = out_st_reg;
    assign found_handle     = out_fh_reg;
    assign found_generation = out_fg_reg;
    assign removed_count    = out_rm_reg;

    assign head   = cell_q[0];
    assign hd_b   = head[BEGO +: ADDR_W];
    assign hd_e   = head[ENDO +: ADDR_W];
    assign hd_own = head[OWNO +: HANDLE_W];
    assign hd_sc  = head[SUBO +: SCW];
    assign wr     = ctl.pop ? (len_reg - LW'(1)) : len_reg;
    assign rm_wide = 32'(rm_cnt_reg);

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            logic [EW-1:0] nb;
            if (gi == TABLE_ENTRIES - 1)
            begin : g_last
                assign nb = push_entry;
            end
            else
            begin : g_mid
                assign nb = cell_q[gi + 1];
            end
            crit_cell #(.EW(EW), .LW(LW), .IDX(gi)) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .wr         (wr),
                .next_entry (nb),
                .push_entry (push_entry),
                .entry      (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        hd_ovl = 1'b0;
        if (hd_sc == '0)
        begin
            hd_ovl = (b_reg < hd_e) && (e_reg > hd_b);
        end
        for (int k = 0; k < SUBRANGES; k++)
        begin
            if ((SCW'(k) < hd_sc) && (b_reg < head[k*2*ADDR_W + ADDR_W +: ADDR_W]) &&
                (e_reg > head[k*2*ADDR_W +: ADDR_W]))
            begin
                hd_ovl = 1'b1;
            end
        end
    end

    always_comb
    begin
        bad = (32'(h_reg) >= HANDLES) || (b_reg >= e_reg);
        new_entry = '0;
        new_entry[BEGO +: ADDR_W]   = b_reg;
        new_entry[ENDO +: ADDR_W]   = e_reg;
        new_entry[OWNO +: HANDLE_W] = h_reg;
        new_entry[SUBO +: SCW]      = staged_cnt_reg;
        for (int k = 0; k < SUBRANGES; k++)
        begin
            if (SCW'(k) < staged_cnt_reg)
            begin
                new_entry[k*2*ADDR_W +: ADDR_W]          = stg_b_reg[k];
                new_entry[k*2*ADDR_W + ADDR_W +: ADDR_W] = stg_e_reg[k];
                if ((stg_b_reg[k] < b_reg) || (stg_e_reg[k] > e_reg) ||
                    (stg_b_reg[k] >= stg_e_reg[k]))
                begin
                    bad = 1'b1;
                end
                if ((k > 0) && (stg_e_reg[(k > 0) ? k - 1 : 0] > stg_b_reg[k]))
                begin
                    bad = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        h_next          = h_reg;
        b_next          = b_reg;
        e_next          = e_reg;
        a_next          = a_reg;
        len_next        = len_reg;
        pass_cnt_next   = pass_cnt_reg;
        ins_pend_next   = ins_pend_reg;
        ins_next        = ins_reg;
        st_next         = st_reg;
        found_next      = found_reg;
        hit_next        = hit_reg;
        fh_next         = fh_reg;
        fg_next         = fg_reg;
        rm_cnt_next     = rm_cnt_reg;
        gaddr_next      = gaddr_reg;
        staged_cnt_next = staged_cnt_reg;
        stg_b_next      = stg_b_reg;
        stg_e_next      = stg_e_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_st_next     = out_st_reg;
        out_fh_next     = out_fh_reg;
        out_fg_next     = out_fg_reg;
        out_rm_next     = out_rm_reg;
        out_valid_next  = result_ready ? 1'b0 : out_valid_reg;
        ctl             = '0;
        push_entry      = head;
        gen_raddr       = gaddr_reg;
        gen_we          = 1'b0;
        gen_waddr       = gaddr_reg;
        gen_wdata       = '0;

        case (state_reg)
            S_CLR:
            begin
                gen_we       = 1'b1;
                gen_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + HW'(1);
                if (32'(clr_cnt_reg) == HANDLES - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (request_valid)
                begin
                    op_next     = operation;
                    h_next      = handle;
                    b_next      = range_begin;
                    e_next      = range_end;
                    a_next      = lookup_address;
                    found_next  = 1'b0;
                    hit_next    = 1'b0;
                    fh_next     = '0;
                    fg_next     = '0;
                    rm_cnt_next = '0;
                    st_next     = ST_OK;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                pass_cnt_next = len_reg;
                gaddr_next    = HW'(h_reg);
                state_next    = S_PASS;
                case (op_reg)
                    OP_STAGE:
                    begin
                        state_next = S_OUT;
                        if (staged_cnt_reg == SCW'(SUBRANGES))
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            for (int k = 0; k < SUBRANGES; k++)
                            begin
                                if (SCW'(k) == staged_cnt_reg)
                                begin
                                    stg_b_next[k] = b_reg;
                                    stg_e_next[k] = e_reg;
                                end
                            end
                            staged_cnt_next = staged_cnt_reg + SCW'(1);
                        end
                    end
                    OP_REGISTER:
                    begin
                        staged_cnt_next = '0;
                        ins_next        = new_entry;
                        ins_pend_next   = 1'b1;
                        if (bad)
                        begin
                            st_next    = ST_INVALID;
                            state_next = S_OUT;
                        end
                        else if (len_reg == LW'(TABLE_ENTRIES))
                        begin
                            st_next    = ST_FULL;
                            state_next = S_OUT;
                        end
                    end
                    OP_REMOVE_HND:
                    begin
                        if (32'(h_reg) >= HANDLES)
                        begin
                            st_next    = ST_INVALID;
                            state_next = S_OUT;
                        end
                    end
                    OP_REMOVE_OVL:
                    begin
                        if (b_reg >= e_reg)
                        begin
                            st_next    = ST_INVALID;
                            state_next = S_OUT;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        state_next = S_PASS;
                    end
                    default:
                    begin
                        st_next    = ST_INVALID;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_PASS:
            begin
                gen_raddr = HW'(hd_own);
                if (pass_cnt_reg == '0)
                begin
                    if ((op_reg == OP_REGISTER) && ins_pend_reg)
                    begin
                        ctl.push      = 1'b1;
                        push_entry    = ins_reg;
                        len_next      = len_reg + LW'(1);
                        ins_pend_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_OUT;
                        case (op_reg)
                            OP_REGISTER:
                            begin
                                state_next = S_GRD;
                            end
                            OP_REMOVE_HND:
                            begin
                                if (hit_reg)
                                begin
                                    state_next = S_GRD;
                                end
                                else
                                begin
                                    st_next = ST_NOT_FOUND;
                                end
                            end
                            OP_LOOKUP:
                            begin
                                gaddr_next = HW'(fh_reg);
                                if (found_reg)
                                begin
                                    state_next = S_GRD;
                                end
                                else
                                begin
                                    st_next = ST_NOT_FOUND;
                                end
                            end
                            default:
                            begin
                                st_next = ST_OK;
                            end
                        endcase
                    end
                end
                else
                begin
                    ctl.pop       = 1'b1;
                    ctl.push      = 1'b1;
                    pass_cnt_next = pass_cnt_reg - LW'(1);
                    case (op_reg)
                        OP_REGISTER:
                        begin
                            if (ins_pend_reg && !((hd_b < b_reg) ||
                                ((hd_b == b_reg) && (hd_e <= e_reg))))
                            begin
                                ctl.pop       = 1'b0;
                                push_entry    = ins_reg;
                                pass_cnt_next = pass_cnt_reg;
                                len_next      = len_reg + LW'(1);
                                ins_pend_next = 1'b0;
                            end
                        end
                        OP_REMOVE_HND:
                        begin
                            if (hd_own == h_reg)
                            begin
                                ctl.push = 1'b0;
                                len_next = len_reg - LW'(1);
                                hit_next = 1'b1;
                            end
                        end
                        OP_REMOVE_OVL:
                        begin
                            if (hd_ovl)
                            begin
                                ctl.push    = 1'b0;
                                len_next    = len_reg - LW'(1);
                                rm_cnt_next = rm_cnt_reg + LW'(1);
                                gaddr_next  = HW'(hd_own);
                                state_next  = S_GUPD;
                            end
                        end
                        default:
                        begin
                            if ((hd_b <= a_reg) && (a_reg < hd_e))
                            begin
                                found_next = 1'b1;
                                fh_next    = hd_own;
                            end
                        end
                    endcase
                end
            end
            S_GUPD:
            begin
                gen_we     = 1'b1;
                gen_wdata  = gen_rd_reg + GEN_W'(1);
                state_next = S_PASS;
            end
            S_GRD:
            begin
                state_next = S_GWR;
            end
            S_GWR:
            begin
                state_next = S_OUT;
                case (op_reg)
                    OP_REGISTER:
                    begin
                        gen_we    = (gen_rd_reg == '0);
                        gen_wdata = GEN_W'(1);
                    end
                    OP_REMOVE_HND:
                    begin
                        gen_we    = 1'b1;
                        gen_wdata = gen_rd_reg + GEN_W'(1);
                    end
                    default:
                    begin
                        fg_next = gen_rd_reg;
                    end
                endcase
            end
            S_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = st_reg;
                    out_fh_next    = fh_reg;
                    out_fg_next    = fg_reg;
                    out_rm_next    = rm_wide[COUNT_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_cnt_reg    <= '0;
            len_reg        <= '0;
            staged_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
            ins_pend_reg   <= 1'b0;
            pass_cnt_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            len_reg        <= len_next;
            staged_cnt_reg <= staged_cnt_next;
            out_valid_reg  <= out_valid_next;
            ins_pend_reg   <= ins_pend_next;
            pass_cnt_reg   <= pass_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        h_reg      <= h_next;
        b_reg      <= b_next;
        e_reg      <= e_next;
        a_reg      <= a_next;
        ins_reg    <= ins_next;
        st_reg     <= st_next;
        found_reg  <= found_next;
        hit_reg    <= hit_next;
        fh_reg     <= fh_next;
        fg_reg     <= fg_next;
        rm_cnt_reg <= rm_cnt_next;
        gaddr_reg  <= gaddr_next;
        stg_b_reg  <= stg_b_next;
        stg_e_reg  <= stg_e_next;
        out_st_reg <= out_st_next;
        out_fh_reg <= out_fh_next;
        out_fg_reg <= out_fg_next;
        out_rm_reg <= out_rm_next;
    end

    always_ff @(posedge clk)
    begin
        if (gen_we)
        begin
            gen_mem[gen_waddr] <= gen_wdata;
        end
        gen_rd_reg <= gen_mem[gen_raddr];
    end

    `CRIT_ASSERT_SAME(a_len_bound, 1'b1, len_reg <= LW'(TABLE_ENTRIES), "Table overfilled.")
    `CRIT_ASSERT_SAME(a_push_room, ctl.push && !ctl.pop, len_reg < LW'(TABLE_ENTRIES),
        "Insert into a full row of cells.")
    `CRIT_ASSERT_SAME(a_stage_bound, 1'b1, staged_cnt_reg <= SCW'(SUBRANGES),
        "Staging count out of range.")
    `CRIT_ASSERT_NEXT(a_accept_busy, request_valid && request_ready, state_reg == S_CHECK,
        "Accepted request not taken up.")

endmodule

`default_nettype wire
